@@ sv/ohc_pkg.sv @@
// ----------------------------------------------------------------------------
// ohc_pkg: shared types and constants of the orientation hold classifier
// Item structs, class codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ohc_pkg;

  // Orientation class codes
  typedef enum logic [1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_UPRIGHT  = 2'd1,
    CLS_SIDEWAYS = 2'd2
  } class_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAJOR_THRESHOLD = 2'd0,
    REG_MINOR_TOLERANCE = 2'd1,
    REG_HOLD_TICKS      = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] MajorThresholdRst = 16'd711;  // 9.80665 - 2.7 m/s^2
  localparam logic [15:0] MinorToleranceRst = 16'd270;  // 2.7 m/s^2
  localparam logic [31:0] HoldTicksRst      = 32'd1000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    class_e raw_class;
    class_e stable_class;
    class_e previous_stable_class;
  } out_item_t;

endpackage

@@ sv/ohc_classify.sv @@
// ----------------------------------------------------------------------------
// ohc_classify: raw orientation class of one sample
// Compares axis magnitudes against the major threshold and minor tolerance.
// ----------------------------------------------------------------------------
module ohc_classify (
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic        [15:0] major_threshold_i,
  input  logic        [15:0] minor_tolerance_i,
  output ohc_pkg::class_e    raw_class_o
);

  logic [16:0] mag_x, mag_y, mag_z;
  logic [16:0] major_ext, minor_ext;
  logic        x_minor, y_minor, z_minor, x_major, y_major;

  // Exact magnitude: 17 bits so that -32768 maps to 32768
  assign mag_x = accel_x_i[15] ? (17'd0 - {accel_x_i[15], accel_x_i}) : {1'b0, accel_x_i};
  assign mag_y = accel_y_i[15] ? (17'd0 - {accel_y_i[15], accel_y_i}) : {1'b0, accel_y_i};
  assign mag_z = accel_z_i[15] ? (17'd0 - {accel_z_i[15], accel_z_i}) : {1'b0, accel_z_i};

  assign major_ext = {1'b0, major_threshold_i};
  assign minor_ext = {1'b0, minor_tolerance_i};

  assign x_major = mag_x > major_ext;
  assign y_major = mag_y > major_ext;
  assign x_minor = mag_x <= minor_ext;
  assign y_minor = mag_y <= minor_ext;
  assign z_minor = mag_z <= minor_ext;

  // Upright takes priority over sideways
  always_comb begin
    if (y_major && x_minor && z_minor) begin
      raw_class_o = ohc_pkg::CLS_UPRIGHT;
    end else if (x_major && y_minor && z_minor) begin
      raw_class_o = ohc_pkg::CLS_SIDEWAYS;
    end else begin
      raw_class_o = ohc_pkg::CLS_UNKNOWN;
    end
  end

endmodule

@@ sv/orientation_hold_classifier.sv @@
// ----------------------------------------------------------------------------
// orientation_hold_classifier: accelerometer orientation with hold debounce
// Classifies each sample as upright, sideways or unknown and debounces the
// class against a tick-based hold time.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   input    | in        | in_valid_i/in_stall_o | in_item_i  (ohc_pkg::in_item_t)
//   output   | out       | out_valid_o/out_stall_i | out_item_o (ohc_pkg::out_item_t)
//   config   | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled. An item is
// held in the input register; classification, the hold compare (one 32-bit
// subtract and compare) and the state update then fill the result register,
// from which the result is taken once the output is not stalled.
// Reset clears control state and the debounce state to unknown, and loads
// the register reset values. A stall on the output holds the result register;
// the input register keeps accepting until it too holds an item.
// ----------------------------------------------------------------------------
module orientation_hold_classifier (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sample input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ohc_pkg::in_item_t       in_item_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ohc_pkg::out_item_t      out_item_o,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [ohc_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [15:0] major_threshold_q;
  logic [15:0] minor_tolerance_q;
  logic [31:0] hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_threshold_q <= ohc_pkg::MajorThresholdRst;
      minor_tolerance_q <= ohc_pkg::MinorToleranceRst;
      hold_ticks_q      <= ohc_pkg::HoldTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ohc_pkg::REG_MAJOR_THRESHOLD: major_threshold_q <= cfg_data_i[15:0];
        ohc_pkg::REG_MINOR_TOLERANCE: minor_tolerance_q <= cfg_data_i[15:0];
        ohc_pkg::REG_HOLD_TICKS:      hold_ticks_q      <= cfg_data_i[31:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register stage
  logic              in_valid_q;
  ohc_pkg::in_item_t in_item_q;
  logic              advance;
  logic              in_accept;

  // Move the held item into the result register when it is free or draining
  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  // Classification of the held sample
  ohc_pkg::class_e raw_class;

  ohc_classify u_classify (
    .accel_x_i         (in_item_q.accel_x),
    .accel_y_i         (in_item_q.accel_y),
    .accel_z_i         (in_item_q.accel_z),
    .major_threshold_i (major_threshold_q),
    .minor_tolerance_i (minor_tolerance_q),
    .raw_class_o       (raw_class)
  );

  // Debounce state
  ohc_pkg::class_e last_raw_q, last_raw_d;
  logic [31:0]     hold_start_q, hold_start_d;
  ohc_pkg::class_e stable_now_q, stable_now_d;
  ohc_pkg::class_e stable_before_q, stable_before_d;
  logic [31:0]     elapsed;

  // Wrapping elapsed time since the raw class last changed
  assign elapsed = in_item_q.now_tick - hold_start_q;

  always_comb begin
    last_raw_d      = last_raw_q;
    hold_start_d    = hold_start_q;
    stable_now_d    = stable_now_q;
    stable_before_d = stable_before_q;
    if (raw_class != last_raw_q) begin
      // new raw class: restart the hold timer
      last_raw_d   = raw_class;
      hold_start_d = in_item_q.now_tick;
    end else if (raw_class != ohc_pkg::CLS_UNKNOWN) begin
      // class held long enough: promote it, repeating on every later match
      if (elapsed >= hold_ticks_q) begin
        stable_before_d = stable_now_q;
        stable_now_d    = raw_class;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q      <= ohc_pkg::CLS_UNKNOWN;
      hold_start_q    <= 32'd0;
      stable_now_q    <= ohc_pkg::CLS_UNKNOWN;
      stable_before_q <= ohc_pkg::CLS_UNKNOWN;
    end else if (advance) begin
      last_raw_q      <= last_raw_d;
      hold_start_q    <= hold_start_d;
      stable_now_q    <= stable_now_d;
      stable_before_q <= stable_before_d;
    end
  end

  // Result register
  logic               out_valid_q;
  ohc_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.raw_class             <= raw_class;
      out_item_q.stable_class          <= stable_now_d;
      out_item_q.previous_stable_class <= stable_before_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ sv/ohc_checker.sv @@
// ----------------------------------------------------------------------------
// ohc_checker: port-level checks of the orientation hold classifier
// Watches the handshakes and the class sequence of delivered items.
// ----------------------------------------------------------------------------
module ohc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  ohc_pkg::out_item_t out_item_o
);

  logic            out_take;
  logic            seen_q;
  ohc_pkg::class_e stable_q;
  ohc_pkg::class_e before_q;

  assign out_take = out_valid_o && !out_stall_i;

  // Track the last delivered stable pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      stable_q <= ohc_pkg::CLS_UNKNOWN;
      before_q <= ohc_pkg::CLS_UNKNOWN;
    end else if (out_take) begin
      seen_q   <= 1'b1;
      stable_q <= out_item_o.stable_class;
      before_q <= out_item_o.previous_stable_class;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // An empty result register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // An unknown sample leaves the stable pair alone
  a_unknown_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q && out_item_o.raw_class == ohc_pkg::CLS_UNKNOWN |->
      out_item_o.stable_class == stable_q &&
      out_item_o.previous_stable_class == before_q)
    else $error("unknown sample changed the stable class");

  // A stable update takes the raw class and shifts the old stable class
  a_update_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q && (out_item_o.stable_class != stable_q ||
      out_item_o.previous_stable_class != before_q) |->
      out_item_o.stable_class == out_item_o.raw_class &&
      out_item_o.previous_stable_class == stable_q)
    else $error("stable update does not follow the raw class");

endmodule

bind orientation_hold_classifier ohc_checker u_ohc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
